// ===== hdl/okvs_pkg.sv =====
// Package with the sizes, operation codes and sequencer states of the ordered key-value store.
`timescale 1ns / 1ps

package okvs_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 3;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int WORD_W      = KEY_W + VAL_W;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_LOOKUP    = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_RESET_CUR = 3'd3,
    OP_ADVANCE   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_MISS,
    S_CUR,
    S_CURW,
    S_DONE
  } state_t;

endpackage

// ===== hdl/ordered_key_value_store.sv =====
// Top level of the ordered key-value store: entry memory, search and shift sequencer, result register.
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid in_ready in_op in_key in_value     | in
//  result  | out_valid out_ready out_hit out_found_value | out
//          | out_cursor_key out_cursor_value             |
//          | out_cursor_at_end out_entry_count           |
//          | out_full_error                              |
//
// One item is handled at a time over an entry memory with one write port and a registered read.
// Each entry searched passes through a read and a compare state, and each entry moved on a removal
// through a shift read and a shift write. A search that misses adds a miss step, and the cursor
// fetch, the result load and the return to idle close every item.
// Reset clears the count, the cursor and the control state; the memory keeps its contents.
// A result that is not taken holds in the output register; the next item is still taken but
// waits in its last step until the register is free.
`timescale 1ns / 1ps

module ordered_key_value_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [okvs_pkg::OP_W-1:0]           in_op,
  input  logic signed [okvs_pkg::KEY_W-1:0]   in_key,
  input  logic [okvs_pkg::VAL_W-1:0]          in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [okvs_pkg::VAL_W-1:0]          out_found_value,
  output logic signed [okvs_pkg::KEY_W-1:0]   out_cursor_key,
  output logic [okvs_pkg::VAL_W-1:0]          out_cursor_value,
  output logic                                out_cursor_at_end,
  output logic [okvs_pkg::COUNT_OUT_W-1:0]    out_entry_count,
  output logic                                out_full_error
);

  import okvs_pkg::*;

  logic [WORD_W-1:0] mem_r [CAPACITY];
  logic [WORD_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic              hit_r, hit_nxt;
  logic              full_r, full_nxt;
  logic              end_r, end_nxt;
  logic [VAL_W-1:0]  found_r, found_nxt;
  logic [KEY_W-1:0]  ck_r, ck_nxt;
  logic [VAL_W-1:0]  cv_r, cv_nxt;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_found_r;
  logic [KEY_W-1:0]  out_ck_r;
  logic [VAL_W-1:0]  out_cv_r;
  logic              out_end_r;
  logic [COUNT_OUT_W-1:0] out_cnt_r;
  logic              out_full_r;

  logic              key_match;
  logic              last_slot;
  logic              more_after;
  logic              shift_more;
  logic              out_free;
  logic [CNT_W-1:0]  cur_dec;
  logic [CNT_W-1:0]  cnt_dec;

  assign key_match  = (rd_data_r[WORD_W-1:VAL_W] == key_r);
  assign last_slot  = ((idx_r + CNT_W'(1)) == cnt_r);
  assign more_after = ((idx_r + CNT_W'(1)) < cnt_r);
  assign shift_more = ((idx_r + CNT_W'(1)) < cnt_r);
  assign out_free   = !out_valid_r || out_ready;
  assign cnt_dec    = cnt_r - CNT_W'(1);
  assign cur_dec    = (cur_r > idx_r) ? (cur_r - CNT_W'(1)) : cur_r;
  assign in_ready   = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_INSERT, OP_LOOKUP, OP_REMOVE: state_nxt = (cnt_r == '0) ? S_MISS : S_RD;
            default:                         state_nxt = S_CUR;
          endcase
        end
      end
      S_RD:   state_nxt = S_CMP;
      S_CMP: begin
        if (key_match) begin
          state_nxt = (op_r == OP_REMOVE && more_after) ? S_SHRD : S_CUR;
        end else begin
          state_nxt = last_slot ? S_MISS : S_RD;
        end
      end
      S_SHRD: state_nxt = S_SHWR;
      S_SHWR: state_nxt = shift_more ? S_SHRD : S_CUR;
      S_MISS: state_nxt = S_CUR;
      S_CUR:  state_nxt = (cur_r < cnt_r) ? S_CURW : S_DONE;
      S_CURW: state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    hit_nxt   = hit_r;
    full_nxt  = full_r;
    end_nxt   = end_r;
    found_nxt = found_r;
    ck_nxt    = ck_r;
    cv_nxt    = cv_r;
    mem_we    = 1'b0;
    wr_addr   = idx_r[IDX_W-1:0];
    wr_data   = {key_r, val_r};
    rd_addr   = idx_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          key_nxt   = in_key;
          val_nxt   = in_value;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          full_nxt  = 1'b0;
          found_nxt = '0;
          case (in_op)
            OP_RESET_CUR: cur_nxt = '0;
            OP_ADVANCE: begin
              if (cur_r < cnt_r) begin
                cur_nxt = cur_r + CNT_W'(1);
              end
            end
            default: cur_nxt = cur_r;
          endcase
        end
      end
      S_CMP: begin
        if (key_match) begin
          hit_nxt = 1'b1;
          case (op_r)
            OP_INSERT: mem_we = 1'b1;
            OP_LOOKUP: found_nxt = rd_data_r[VAL_W-1:0];
            OP_REMOVE: begin
              cnt_nxt = cnt_dec;
              cur_nxt = (cur_dec > cnt_dec) ? cnt_dec : cur_dec;
            end
            default: hit_nxt = 1'b1;
          endcase
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_SHRD: rd_addr = IDX_W'(idx_r + CNT_W'(1));
      S_SHWR: begin
        mem_we  = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = idx_r + CNT_W'(1);
      end
      S_MISS: begin
        if (op_r == OP_INSERT) begin
          if (cnt_r < CNT_W'(CAPACITY)) begin
            mem_we  = 1'b1;
            wr_addr = cnt_r[IDX_W-1:0];
            cnt_nxt = cnt_r + CNT_W'(1);
            if (cur_r >= cnt_r) begin
              cur_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            full_nxt = 1'b1;
          end
        end
      end
      S_CUR: begin
        rd_addr = cur_r[IDX_W-1:0];
        if (cur_r < cnt_r) begin
          end_nxt = 1'b0;
        end else begin
          end_nxt = 1'b1;
          ck_nxt  = '0;
          cv_nxt  = '0;
        end
      end
      S_CURW: begin
        ck_nxt = rd_data_r[WORD_W-1:VAL_W];
        cv_nxt = rd_data_r[VAL_W-1:0];
      end
      default: begin
        rd_addr = idx_r[IDX_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    full_r  <= full_nxt;
    end_r   <= end_nxt;
    found_r <= found_nxt;
    ck_r    <= ck_nxt;
    cv_r    <= cv_nxt;
    if (state_r == S_DONE && out_free) begin
      out_hit_r   <= hit_r;
      out_found_r <= found_r;
      out_ck_r    <= ck_r;
      out_cv_r    <= cv_r;
      out_end_r   <= end_r;
      out_cnt_r   <= COUNT_OUT_W'(cnt_r);
      out_full_r  <= full_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_found_value   = out_found_r;
  assign out_cursor_key    = out_ck_r;
  assign out_cursor_value  = out_cv_r;
  assign out_cursor_at_end = out_end_r;
  assign out_entry_count   = out_cnt_r;
  assign out_full_error    = out_full_r;

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= cnt_r)
    else $error("Cursor lies beyond the stored entries.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second item was taken while one is in progress.");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cursor_at_end |-> out_cursor_key == '0 && out_cursor_value == '0)
    else $error("Cursor fields are not zero at the end of the table.");

  a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_full_error))
    else $error("An item reports both a hit and a full table.");

endmodule

// ===== tb/ordered_key_value_store_tb.sv =====
// Self-checking testbench for the ordered key-value store: directed table, random phases, shadow predictor.
`timescale 1ns / 1ps

module ordered_key_value_store_tb;
  import okvs_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int ITEMS_PER_PHASE  = 150;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 150;
  localparam int KEY_POOL_SIZE    = 24;

  typedef struct packed {
    logic                   hit;
    logic [VAL_W-1:0]       found_value;
    logic [KEY_W-1:0]       cursor_key;
    logic [VAL_W-1:0]       cursor_value;
    logic                   cursor_at_end;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   full_error;
  } store_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [7:0]       reps;
    logic             typed;
    store_result_t    want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [OP_W-1:0]        in_op;
  logic signed [KEY_W-1:0] in_key;
  logic [VAL_W-1:0]       in_value;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_hit;
  logic [VAL_W-1:0]       out_found_value;
  logic signed [KEY_W-1:0] out_cursor_key;
  logic [VAL_W-1:0]       out_cursor_value;
  logic                   out_cursor_at_end;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic                   out_full_error;

  logic [KEY_W-1:0] shadow_keys [CAPACITY];
  logic [VAL_W-1:0] shadow_values [CAPACITY];
  int               shadow_count;
  int               shadow_cursor;

  store_result_t result_q [$];
  stim_row_t     directed_rows [$];
  logic          item_typed;
  store_result_t item_want;
  store_result_t predicted;
  store_result_t oldest;
  int            mismatch_count;
  int            sender_idle_pct;
  int            rx_stall_pct;
  logic          long_hold_req;
  logic          long_hold_done;
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

  ordered_key_value_store dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_key            (in_key),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_found_value   (out_found_value),
    .out_cursor_key    (out_cursor_key),
    .out_cursor_value  (out_cursor_value),
    .out_cursor_at_end (out_cursor_at_end),
    .out_entry_count   (out_entry_count),
    .out_full_error    (out_full_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL ordered_key_value_store");
    $finish;
  end

  function automatic store_result_t apply_store_op(input logic [OP_W-1:0] op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] value);
    int slot;
    store_result_t res;
    res = '0;
    slot = shadow_count;
    for (int i = 0; i < shadow_count; i++) begin
      if (slot == shadow_count && shadow_keys[i] == key) slot = i;
    end
    case (op)
      OP_INSERT: begin
        if (slot < shadow_count) begin
          shadow_values[slot] = value;
          res.hit = 1'b1;
        end else if (shadow_count < CAPACITY) begin
          if (shadow_cursor >= shadow_count) shadow_cursor = shadow_count + 1;
          shadow_keys[shadow_count] = key;
          shadow_values[shadow_count] = value;
          shadow_count++;
        end else begin
          res.full_error = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (slot < shadow_count) begin
          res.hit = 1'b1;
          res.found_value = shadow_values[slot];
        end
      end
      OP_REMOVE: begin
        if (slot < shadow_count) begin
          res.hit = 1'b1;
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_values[i] = shadow_values[i + 1];
          end
          shadow_count--;
          if (shadow_cursor > slot) shadow_cursor--;
          if (shadow_cursor > shadow_count) shadow_cursor = shadow_count;
        end
      end
      OP_RESET_CUR: shadow_cursor = 0;
      OP_ADVANCE: begin
        if (shadow_cursor < shadow_count) shadow_cursor++;
      end
      default: ;
    endcase
    res.cursor_at_end = (shadow_cursor >= shadow_count);
    if (!res.cursor_at_end) begin
      res.cursor_key = shadow_keys[shadow_cursor];
      res.cursor_value = shadow_values[shadow_cursor];
    end
    res.entry_count = shadow_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic store_result_t typed_result(input logic hit, input logic [VAL_W-1:0] found,
                                                 input logic [KEY_W-1:0] ckey,
                                                 input logic [VAL_W-1:0] cval, input logic at_end,
                                                 input int count, input logic full);
    store_result_t res;
    res.hit = hit;
    res.found_value = found;
    res.cursor_key = ckey;
    res.cursor_value = cval;
    res.cursor_at_end = at_end;
    res.entry_count = count[COUNT_OUT_W-1:0];
    res.full_error = full;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = apply_store_op(in_op, in_key, in_value);
        result_q.push_back(item_typed ? item_want : predicted);
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result arrived with no item outstanding");
          mismatch_count++;
        end else begin
          oldest = result_q.pop_front();
          check_field("hit", 32'(oldest.hit), 32'(out_hit));
          check_field("found_value", oldest.found_value, out_found_value);
          check_field("cursor_key", oldest.cursor_key, out_cursor_key);
          check_field("cursor_value", oldest.cursor_value, out_cursor_value);
          check_field("cursor_at_end", 32'(oldest.cursor_at_end), 32'(out_cursor_at_end));
          check_field("entry_count", 32'(oldest.entry_count), 32'(out_entry_count));
          check_field("full_error", 32'(oldest.full_error), 32'(out_full_error));
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        out_ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value, input logic typed,
                           input store_result_t want);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid = 1'b1;
    in_op = op;
    in_key = key;
    in_value = value;
    item_typed = typed;
    item_want = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value, input int reps, input logic typed,
                         input store_result_t want);
    stim_row_t row;
    row.op = op;
    row.key = key;
    row.value = value;
    row.reps = reps[7:0];
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_random_item();
    int pick;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 36) op = OP_INSERT;
    else if (pick < 56) op = OP_LOOKUP;
    else if (pick < 76) op = OP_REMOVE;
    else if (pick < 84) op = OP_RESET_CUR;
    else if (pick < 96) op = OP_ADVANCE;
    else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    else key = $urandom;
    send_item(op, key, $urandom, 1'b0, '0);
  endtask

  initial begin
    store_result_t empty_res;
    stim_row_t row;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_key = '0;
    in_value = '0;
    item_typed = 1'b0;
    item_want = '0;
    mismatch_count = 0;
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    long_hold_req = 1'b0;
    shadow_count = 0;
    shadow_cursor = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_keys[i] = '0;
      shadow_values[i] = '0;
    end

    empty_res = typed_result(1'b0, '0, '0, '0, 1'b1, 0, 1'b0);
    add_row(OP_LOOKUP, 32'h0, 32'h0, 1, 1'b1, empty_res);
    add_row(OP_ADVANCE, 32'h0, 32'h0, 1, 1'b1, empty_res);
    add_row(OP_RESET_CUR, 32'h0, 32'h0, 1, 1'b1, empty_res);
    add_row(OP_REMOVE, 32'h5, 32'h0, 1, 1'b1, empty_res);
    add_row(OP_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, empty_res);
    add_row(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1,
            typed_result(1'b0, '0, '0, '0, 1'b1, 1, 1'b0));
    add_row(OP_INSERT, 32'h7FFF_FFFF, 32'h0, 1, 1'b1,
            typed_result(1'b0, '0, '0, '0, 1'b1, 2, 1'b0));
    add_row(OP_ADVANCE, 32'h0, 32'h0, 1, 1'b1,
            typed_result(1'b0, '0, '0, '0, 1'b1, 2, 1'b0));
    add_row(OP_RESET_CUR, 32'h0, 32'h0, 1, 1'b1,
            typed_result(1'b0, '0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 2, 1'b0));
    add_row(OP_ADVANCE, 32'h0, 32'h0, 1, 1'b1,
            typed_result(1'b0, '0, 32'h7FFF_FFFF, 32'h0, 1'b0, 2, 1'b0));
    add_row(OP_REMOVE, 32'h7FFF_FFFF, 32'h0, 1, 1'b1,
            typed_result(1'b1, '0, '0, '0, 1'b1, 1, 1'b0));
    add_row(OP_LOOKUP, 32'h8000_0000, 32'h0, 1, 1'b0, '0);
    add_row(OP_INSERT, 32'h8000_0000, 32'h1234_5678, 1, 1'b0, '0);
    add_row(OP_RESET_CUR, 32'h0, 32'h0, 1, 1'b0, '0);
    add_row(OP_INSERT, 32'h4000_0000, 32'h0F0F_0F0F, CAPACITY - 1, 1'b0, '0);
    add_row(OP_INSERT, 32'h7, 32'hDEAD_BEEF, 1, 1'b1,
            typed_result(1'b0, '0, 32'h8000_0000, 32'h1234_5678, 1'b0, CAPACITY, 1'b1));
    add_row(OP_INSERT, 32'h4000_0003, 32'hA5A5_A5A5, 1, 1'b0, '0);
    add_row(OP_ADVANCE, 32'h0, 32'h0, 2, 1'b0, '0);
    add_row(OP_REMOVE, 32'h8000_0000, 32'h0, 1, 1'b0, '0);
    add_row(OP_REMOVE, 32'h4000_0001, 32'h0, 1, 1'b0, '0);
    add_row(OP_REMOVE, 32'd77, 32'h0, 1, 1'b0, '0);
    add_row(OP_SPARE_LAST, 32'h0, 32'h0, 1, 1'b0, '0);
    add_row(OP_LOOKUP, 32'h8000_0000, 32'h0, 1, 1'b0, '0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int n = 0; n < row.reps; n++) begin
        send_item(row.op, row.key + n, row.value + n, row.typed, row.want);
      end
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 74;
          rx_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          rx_stall_pct = 74;
          long_hold_req = 1'b1;
        end
        default: begin
          sender_idle_pct = 17;
          rx_stall_pct = 17;
        end
      endcase
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      repeat (ITEMS_PER_PHASE) send_random_item();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("PASS ordered_key_value_store");
    end else begin
      $display("FAIL ordered_key_value_store");
    end
    $finish;
  end

endmodule
